### hdl/rmv_pkg.sv
`default_nettype none

package rmv_pkg;

    // Fixed field widths
    localparam int MEAN_BITS  = 48;
    localparam int SUM_BITS   = 63;
    localparam int COUNT_BITS = 32;

    // Defaults for the top-level parameters
    localparam int DEF_SAMPLE_BITS = 32;
    localparam int DEF_FRAC_BITS   = 16;

    // |delta| and |x - new mean| both fit the mean width as magnitudes
    localparam int MAG_BITS  = MEAN_BITS;
    localparam int PROD_BITS = 2 * MAG_BITS;
    localparam int STEP_BITS = $clog2(MAG_BITS);

    localparam logic [MEAN_BITS-1:0] MEAN_MAX = {1'b0, {(MEAN_BITS-1){1'b1}}};
    localparam logic [MEAN_BITS-1:0] MEAN_MIN = {1'b1, {(MEAN_BITS-1){1'b0}}};
    localparam logic [SUM_BITS-1:0]  SUM_MAX  = {SUM_BITS{1'b1}};

    // Sequencer commands to the shift unit
    typedef struct packed {
        logic load_div;
        logic step_div;
        logic load_mul;
        logic step_mul;
    } t_unit_ctrl;

endpackage

`default_nettype wire

### hdl/rmv_shift_unit.sv
`default_nettype none

// Radix-2 shift unit: restoring divide (one quotient bit per cycle) and
// shift-add multiply (one multiplier bit per cycle), sharing one shift register.
module rmv_shift_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rmv_pkg::t_unit_ctrl               i_ctrl,
    input  wire logic [rmv_pkg::MAG_BITS-1:0]      i_mag,
    input  wire logic [rmv_pkg::COUNT_BITS-1:0]    i_divisor,
    output logic      [rmv_pkg::MAG_BITS-1:0]      o_quotient,
    output logic      [rmv_pkg::PROD_BITS-1:0]     o_product,
    output logic                                   o_last
);
    import rmv_pkg::*;

    logic [MAG_BITS-1:0]   r_sh,    n_sh;
    logic [MAG_BITS-1:0]   r_acc,   n_acc;
    logic [MAG_BITS-1:0]   r_mcand, n_mcand;
    logic [COUNT_BITS-1:0] r_rem,   n_rem;
    logic [STEP_BITS-1:0]  r_step,  n_step;

    logic [COUNT_BITS:0]   w_trial;
    logic [COUNT_BITS:0]   w_trial_sub;
    logic                  w_ge;
    logic [MAG_BITS:0]     w_psum;

    // Divide step: bring down the next dividend bit, subtract if it fits
    assign w_trial     = {r_rem, r_sh[MAG_BITS-1]};
    assign w_trial_sub = w_trial - {1'b0, i_divisor};
    assign w_ge        = (w_trial >= {1'b0, i_divisor});

    // Multiply step: add multiplicand when the low multiplier bit is set
    assign w_psum = {1'b0, r_acc} + (r_sh[0] ? {1'b0, r_mcand} : '0);

    always_comb begin
        n_sh    = r_sh;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        n_rem   = r_rem;
        n_step  = r_step;
        if (i_ctrl.load_div) begin
            n_sh    = i_mag;
            n_mcand = i_mag;
            n_rem   = '0;
            n_step  = '0;
        end else if (i_ctrl.step_div) begin
            n_rem  = w_ge ? w_trial_sub[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
            n_sh   = {r_sh[MAG_BITS-2:0], w_ge};
            n_step = r_step + 1'b1;
        end else if (i_ctrl.load_mul) begin
            n_sh   = i_mag;
            n_acc  = '0;
            n_step = '0;
        end else if (i_ctrl.step_mul) begin
            n_acc  = w_psum[MAG_BITS:1];
            n_sh   = {w_psum[0], r_sh[MAG_BITS-1:1]};
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
        r_sh    <= n_sh;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
        r_rem   <= n_rem;
    end

    assign o_quotient = r_sh;
    assign o_product  = {r_acc, r_sh};
    assign o_last     = (r_step == STEP_BITS'(MAG_BITS - 1));

    // Checks
    a_ctrl_onehot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_ctrl))
        else $error("shift unit got more than one command");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctrl.step_div) && i_ctrl.step_div |-> r_rem < i_divisor)
        else $error("partial remainder not below divisor");

    a_acc_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctrl.step_mul) |-> r_acc <= r_mcand)
        else $error("partial product high word exceeds multiplicand");

endmodule

`default_nettype wire

### hdl/running_mean_variance.sv
`default_nettype none

// Channel  Direction  Handshake                 Beat fields
// -------  ---------  ------------------------  ------------------------------------
// in       input      i_valid / o_stall         i_sample, i_sample_count
// out      output     o_valid / i_stall         o_mean, o_deviation_sum, o_count_error
//
// A nonzero-count beat runs, after acceptance, through setup, the bit-serial divide
// of |delta| by the count, the mean update, the bit-serial multiply, summing and
// the output load; the sequencer returns to idle with the output load, and the input
// stays stalled until then, so no new beat is taken before the last one is through.
// A zero-count beat goes straight from acceptance to the output load, skipping the
// divide and the multiply; the mean and the sum stay unchanged.
// Synchronous reset clears the mean, the sum, the sequencer and the output valid.
// The result waits in the output register; a new beat is taken while it waits,
// and a stalled output holds only the final load of the next result.
module running_mean_variance #(
    parameter int SAMPLE_BITS = rmv_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = rmv_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  wire logic        [rmv_pkg::COUNT_BITS-1:0] i_sample_count,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed      [rmv_pkg::MEAN_BITS-1:0]  o_mean,
    output logic             [rmv_pkg::SUM_BITS-1:0]   o_deviation_sum,
    output logic                                       o_count_error
);
    import rmv_pkg::*;

    localparam int XW = (SAMPLE_BITS + FRAC_BITS > MEAN_BITS) ?
                        SAMPLE_BITS + FRAC_BITS : MEAN_BITS;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_DIFF  = 10'b00_0000_0010,
        S_LOADD = 10'b00_0000_0100,
        S_DIV   = 10'b00_0000_1000,
        S_UPD   = 10'b00_0001_0000,
        S_ERR   = 10'b00_0010_0000,
        S_LOADM = 10'b00_0100_0000,
        S_MUL   = 10'b00_1000_0000,
        S_ACC   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    t_state                 r_state, n_state;
    logic [MEAN_BITS-1:0]   r_mean,  n_mean;
    logic [SUM_BITS-1:0]    r_sum,   n_sum;
    logic [MEAN_BITS-1:0]   r_xs,    n_xs;
    logic [COUNT_BITS-1:0]  r_cnt,   n_cnt;
    logic [MEAN_BITS:0]     r_diff,  n_diff;
    logic                   r_neg,   n_neg;
    logic                   r_err,   n_err;
    logic                   r_out_valid, n_out_valid;
    logic [MEAN_BITS-1:0]   r_out_mean,  n_out_mean;
    logic [SUM_BITS-1:0]    r_out_sum,   n_out_sum;
    logic                   r_out_err,   n_out_err;

    t_unit_ctrl             w_ctrl;
    logic [MAG_BITS-1:0]    w_quo;
    logic [PROD_BITS-1:0]   w_prod;
    logic                   w_last;

    logic                   w_in_acc;
    logic [XW-1:0]          w_x_wide;
    logic [XW-MEAN_BITS:0]  w_x_top;
    logic                   w_x_fits;
    logic [MEAN_BITS-1:0]   w_xs;
    logic [MEAN_BITS:0]     w_sub;
    logic [MEAN_BITS:0]     w_diff_neg;
    logic [MAG_BITS-1:0]    w_mag;
    logic [MEAN_BITS-1:0]   w_new_mean;
    logic                   w_over;
    logic [SUM_BITS-1:0]    w_inc;
    logic [SUM_BITS:0]      w_total;

    assign w_in_acc = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);

    // Scale sample to the mean format, saturating when it does not fit
    assign w_x_wide = {{(XW-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample} << FRAC_BITS;
    assign w_x_top  = w_x_wide[XW-1:MEAN_BITS-1];
    assign w_x_fits = (&w_x_top) || !(|w_x_top);
    assign w_xs     = w_x_fits ? w_x_wide[MEAN_BITS-1:0] :
                      (w_x_wide[XW-1] ? MEAN_MIN : MEAN_MAX);

    // x - mean, sign-extended by one bit; magnitude of the stored difference
    assign w_sub      = {r_xs[MEAN_BITS-1], r_xs} - {r_mean[MEAN_BITS-1], r_mean};
    assign w_diff_neg = (~r_diff) + (MEAN_BITS+1)'(1);
    assign w_mag      = r_diff[MEAN_BITS] ? w_diff_neg[MAG_BITS-1:0] : r_diff[MAG_BITS-1:0];

    // Mean moves toward the sample by the truncated quotient
    assign w_new_mean = r_neg ? (r_mean - w_quo) : (r_mean + w_quo);

    // Drop fraction bits of the product, saturate, then add to the sum
    assign w_over  = |w_prod[PROD_BITS-1:SUM_BITS+FRAC_BITS];
    assign w_inc   = w_over ? SUM_MAX : w_prod[SUM_BITS+FRAC_BITS-1:FRAC_BITS];
    assign w_total = {1'b0, r_sum} + {1'b0, w_inc};

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_mean      = r_mean;
        n_sum       = r_sum;
        n_xs        = r_xs;
        n_cnt       = r_cnt;
        n_diff      = r_diff;
        n_neg       = r_neg;
        n_err       = r_err;
        n_out_valid = r_out_valid && i_stall;
        n_out_mean  = r_out_mean;
        n_out_sum   = r_out_sum;
        n_out_err   = r_out_err;
        w_ctrl      = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_xs  = w_xs;
                    n_cnt = i_sample_count;
                    if (i_sample_count == '0) begin
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_DIFF;
                    end
                end
            end
            S_DIFF: begin
                n_diff  = w_sub;
                n_state = S_LOADD;
            end
            S_LOADD: begin
                w_ctrl.load_div = 1'b1;
                n_neg   = r_diff[MEAN_BITS];
                n_state = S_DIV;
            end
            S_DIV: begin
                w_ctrl.step_div = 1'b1;
                if (w_last) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_mean  = w_new_mean;
                n_state = S_ERR;
            end
            S_ERR: begin
                n_diff  = w_sub;
                n_state = S_LOADM;
            end
            S_LOADM: begin
                w_ctrl.load_mul = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                w_ctrl.step_mul = 1'b1;
                if (w_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_sum   = w_total[SUM_BITS] ? SUM_MAX : w_total[SUM_BITS-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_mean  = r_mean;
                    n_out_sum   = r_sum;
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mean      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mean      <= n_mean;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_xs       <= n_xs;
        r_cnt      <= n_cnt;
        r_diff     <= n_diff;
        r_neg      <= n_neg;
        r_err      <= n_err;
        r_out_mean <= n_out_mean;
        r_out_sum  <= n_out_sum;
        r_out_err  <= n_out_err;
    end

    rmv_shift_unit u_shift (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_mag      (w_mag),
        .i_divisor  (r_cnt),
        .o_quotient (w_quo),
        .o_product  (w_prod),
        .o_last     (w_last)
    );

    assign o_valid         = r_out_valid;
    assign o_mean          = r_out_mean;
    assign o_deviation_sum = r_out_sum;
    assign o_count_error   = r_out_err;

    // Checks
    a_zero_count_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_sample_count == '0) |=> r_state == S_DONE)
        else $error("zero count beat did not go straight to result");

    a_mean_only_in_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_UPD |=> $stable(r_mean))
        else $error("mean changed outside its update step");

    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_sum >= $past(r_sum))
        else $error("deviation sum decreased");

    a_err_result_unchanged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_err |-> r_cnt == '0)
        else $error("error flag set for a nonzero count");

endmodule

`default_nettype wire

### tb/sv/rmv_checker.sv
`default_nettype none

// Watches both channels of running_mean_variance, folds every accepted input
// beat into its own copy of the running mean and deviation sum, and compares
// each output beat against the oldest prediction.
module rmv_checker #(
    parameter int SAMPLE_BITS = rmv_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = rmv_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire logic                                  o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  wire logic        [rmv_pkg::COUNT_BITS-1:0] i_sample_count,
    input  wire logic                                  o_valid,
    input  wire logic                                  i_stall,
    input  wire logic signed [rmv_pkg::MEAN_BITS-1:0]  o_mean,
    input  wire logic        [rmv_pkg::SUM_BITS-1:0]   o_deviation_sum,
    input  wire logic                                  o_count_error,
    output int                                         o_fail_count,
    output int                                         o_pending_count,
    output int                                         o_compared_count,
    output int                                         o_zero_count,
    output int                                         o_sat_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import rmv_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [MEAN_BITS-1:0] mean;
        logic        [SUM_BITS-1:0]  dev_sum;
        logic                        err;
    } t_mv_result;

    // Predicted state: mean in Q.FRAC_BITS, deviation sum saturating
    longint             avg_q;
    logic [SUM_BITS-1:0] devsum_q;

    t_mv_result expected_q[$];

    initial begin
        avg_q            = 0;
        devsum_q         = '0;
        o_fail_count     = 0;
        o_pending_count  = 0;
        o_compared_count = 0;
        o_zero_count     = 0;
        o_sat_count      = 0;
    end

    // One Welford step on the predicted state; returns the beat it should produce
    function automatic t_mv_result fold_sample(input logic signed [SAMPLE_BITS-1:0] x,
                                               input logic [COUNT_BITS-1:0] n);
        longint       mean_hi;
        longint       lim;
        longint       xs;
        longint       delta;
        longint       stp;
        longint       nm;
        longint       resid;
        logic [63:0]  mag_d;
        logic [63:0]  mag_r;
        logic [63:0]  quo;
        logic [127:0] prod;
        logic [SUM_BITS-1:0] inc;
        t_mv_result   r;
        r = '0;
        if (n == '0) begin
            r.err = 1'b1;
        end else begin
            mean_hi = longint'(MEAN_MAX);
            lim     = mean_hi >>> FRAC_BITS;
            xs      = longint'(x);
            // scale to fixed point, clamped to the mean range
            if (xs > lim) begin
                xs = mean_hi;
            end else if (xs < -lim - 1) begin
                xs = -mean_hi - 1;
            end else begin
                xs = xs <<< FRAC_BITS;
            end
            delta = xs - avg_q;
            mag_d = (delta < 0) ? -delta : delta;
            // increment truncates toward zero
            quo   = mag_d / {32'b0, n};
            stp   = (delta < 0) ? -longint'(quo) : longint'(quo);
            nm    = avg_q + stp;
            resid = xs - nm;
            mag_r = (resid < 0) ? -resid : resid;
            prod  = {64'b0, mag_d} * {64'b0, mag_r};
            // floor to FRAC_BITS, saturate if it overflows the sum width
            if (prod[127:SUM_BITS+FRAC_BITS] != '0) begin
                inc = SUM_MAX;
            end else begin
                inc = prod[SUM_BITS+FRAC_BITS-1:FRAC_BITS];
            end
            avg_q = nm;
            if (inc > SUM_MAX - devsum_q) begin
                devsum_q = SUM_MAX;
            end else begin
                devsum_q = devsum_q + inc;
            end
        end
        r.mean    = avg_q[MEAN_BITS-1:0];
        r.dev_sum = devsum_q;
        return r;
    endfunction

    task automatic log_miss(input string what, input t_mv_result want);
        o_fail_count = o_fail_count + 1;
        if (o_fail_count <= REPORT_LIMIT) begin
            $display("%0t MISMATCH %s: exp mean=%h sum=%h err=%b  got mean=%h sum=%h err=%b",
                     $realtime, what, want.mean, want.dev_sum, want.err,
                     o_mean, o_deviation_sum, o_count_error);
        end
    endtask

    // Predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_mv_result want;
        if (!i_rst_n) begin
            avg_q    = 0;
            devsum_q = '0;
            expected_q.delete();
        end else begin
            if (i_valid && !o_stall) begin
                expected_q.push_back(fold_sample(i_sample, i_sample_count));
            end
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    log_miss("output beat with nothing pending", '0);
                end else begin
                    want = expected_q.pop_front();
                    o_compared_count = o_compared_count + 1;
                    if (want.err) o_zero_count = o_zero_count + 1;
                    if (want.dev_sum == SUM_MAX) o_sat_count = o_sat_count + 1;
                    if (o_mean !== want.mean || o_deviation_sum !== want.dev_sum ||
                        o_count_error !== want.err) begin
                        log_miss("field differs", want);
                    end
                end
            end
        end
        o_pending_count = expected_q.size();
    end

endmodule

`default_nettype wire

### tb/sv/tb_running_mean_variance.sv
`default_nettype none

module tb_running_mean_variance;

    timeunit 1ns;
    timeprecision 1ps;

    import rmv_pkg::*;

    localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
    localparam int FRAC_BITS      = DEF_FRAC_BITS;
    localparam int ITEMS_TOTAL    = 950;
    localparam int IDLE_PCT       = 23;
    localparam int CALM_FROM      = 400;
    localparam int CALM_TO        = 560;
    localparam int HOLD_AT_A      = 200;
    localparam int HOLD_AT_B      = 700;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 250;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_valid        = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample       = '0;
    logic        [COUNT_BITS-1:0]  i_sample_count = '0;
    logic                          i_stall        = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic signed [MEAN_BITS-1:0]   o_mean;
    logic        [SUM_BITS-1:0]    o_deviation_sum;
    logic                          o_count_error;

    int fail_count;
    int pending_count;
    int compared_count;
    int zero_count;
    int sat_count;
    int sent_beats   = 0;
    int stuck_cycles = 0;

    always #6 i_clk = ~i_clk;

    running_mean_variance #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .i_sample_count  (i_sample_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_mean          (o_mean),
        .o_deviation_sum (o_deviation_sum),
        .o_count_error   (o_count_error)
    );

    rmv_checker #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample         (i_sample),
        .i_sample_count   (i_sample_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_mean           (o_mean),
        .o_deviation_sum  (o_deviation_sum),
        .o_count_error    (o_count_error),
        .o_fail_count     (fail_count),
        .o_pending_count  (pending_count),
        .o_compared_count (compared_count),
        .o_zero_count     (zero_count),
        .o_sat_count      (sat_count)
    );

    // Offer one beat, with optional idle cycles first; returns on the accepting edge
    task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] s,
                             input logic [COUNT_BITS-1:0] c);
        bit calm;
        calm = (sent_beats >= CALM_FROM) && (sent_beats < CALM_TO);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample       <= s;
        i_sample_count <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_beats++;
    endtask

    // Small signed sample, keeps the deviation sum far from saturation
    function automatic logic signed [SAMPLE_BITS-1:0] small_sample();
        int                            w;
        logic signed [SAMPLE_BITS-1:0] t;
        w = $urandom_range(17, 1);
        t = $urandom;
        return (t <<< (SAMPLE_BITS - w)) >>> (SAMPLE_BITS - w);
    endfunction

    function automatic logic [COUNT_BITS-1:0] odd_count();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(8, 1);
            2:       return '1;
            default: return '0;
        endcase
    endfunction

    // Receiver: random stall, plus two long hold-offs to back up the input
    initial begin
        int in_beats;
        int hold_left;
        bit calm;
        in_beats  = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_valid && !o_stall) begin
                in_beats++;
                if (in_beats == HOLD_AT_A || in_beats == HOLD_AT_B) hold_left = HOLD_CYCLES;
            end
            calm = (in_beats >= CALM_FROM) && (in_beats < CALM_TO);
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles without any beat on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("running_mean_variance verification failed");
            $finish;
        end
    end

    // Stimulus and verdict
    initial begin
        int pick;
        int len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero counts, sample extremes with count one, rounding, count extremes
        send_beat('0, '0);
        send_beat(32'sh7FFF_FFFF, 32'd1);
        send_beat(32'sh8000_0000, 32'd1);
        send_beat(-32'sd1, 32'd1);
        send_beat(32'sh7FFF_FFFF, '0);
        send_beat('0, 32'd1);
        send_beat(32'sd3, 32'd1);
        send_beat(32'sd4, 32'd2);
        send_beat(-32'sd7, 32'd3);
        send_beat(32'sd10, 32'd7);
        send_beat(-32'sd1, 32'd3);
        send_beat(32'sd100, 32'hFFFF_FFFF);
        send_beat(-32'sd100, 32'hFFFF_FFFF);
        send_beat(32'sd1, 32'h8000_0000);
        send_beat(32'sd5, '0);
        send_beat(32'sh0000_FFFF, 32'd1);
        send_beat(32'shFFFF_0001, 32'd2);
        send_beat(32'sd0, 32'd3);

        // random: mostly clean runs counting up from one, then noise
        while (sent_beats < ITEMS_TOTAL) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(24, 2);
                for (int k = 1; k <= len; k++) send_beat(small_sample(), k);
            end else if (pick < 82) begin
                len = $urandom_range(12, 2);
                send_beat(small_sample(), 32'd1);
                for (int k = 1; k < len; k++) send_beat(small_sample(), odd_count());
            end else if (pick < 91) begin
                send_beat($urandom, '0);
            end else begin
                // full-range sample restarts the mean exactly, no deviation added
                send_beat($urandom, 32'd1);
            end
        end

        // sum overflow last, since saturation is sticky
        send_beat(32'sh7FFF_FFFF, 32'd1);
        send_beat(32'sh8000_0000, 32'd2);
        send_beat('0, 32'd3);
        send_beat(32'sd12345, '0);
        repeat (20) send_beat($urandom, $urandom);
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d input beats, %0d results compared, %0d zero-count beats,",
                 sent_beats, compared_count, zero_count);
        $display("         %0d saturated sums, two long output hold-offs with input backed up",
                 sat_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("running_mean_variance verification clean");
        end else begin
            $display("running_mean_variance verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
